// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled under rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kti_pkg.sv =====
// ----------------------------------------------------------------------------
// kti_pkg
// Types and fixed constants of the keyframe target interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kti_pkg;

  localparam int TIME_W = 32;
  localparam int VAL_W  = 32;
  localparam int SEG_W  = 5;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 6;
  localparam int CFG_W  = 5;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_EVAL = 1'b1;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_REPEAT    = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_RD_FIRST = 10'b00_0000_0010,
    S_RD_LAST  = 10'b00_0000_0100,
    S_SPAN     = 10'b00_0000_1000,
    S_FOLD     = 10'b00_0001_0000,
    S_SRCH_RD  = 10'b00_0010_0000,
    S_SRCH_CMP = 10'b00_0100_0000,
    S_DIV      = 10'b00_1000_0000,
    S_MUL      = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

endpackage

// ===== rtl/keyframe_target_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_target_interpolator_core
// Piecewise linear interpolation over a keyframe table, bit-serial datapath.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a load transaction (action 0) writes
// key_time/key_value into slot key_slot in the accepting cycle and leaves the
// block idle. An evaluate transaction (action 1) folds query_time into the
// key span when repeat_enable is set, searches the table, then interpolates.
// Output channel (out_valid / out_stall): one transaction per evaluate with a
// non-empty table, carrying target and segment.
// Steps of an evaluate, in order: in repeat mode, reads of the first and last
// key for the span, then the fold when the query lies above a non-zero span;
// key probes (s+1 when s keys pass and the next lies above the query, n when
// all n pass); the divide and multiply between two keys; a final step.
// The fold is a one-bit-per-cycle restoring remainder over 32 bits, the slope
// a FRAC_BITS-step restoring divide, the product a FRAC_BITS-step shift-add;
// the table has one registered read port, so a key probe reads, then compares.
// in_stall is high from an evaluate's acceptance until its result sits in the
// output register. A stalled result holds; the block accepts new transactions
// meanwhile, but the next evaluate waits in its final step for the register.
// Reset (rst, synchronous) clears control and the configuration registers;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyframe_target_interpolator_core
  import kti_pkg::*;
#(
  parameter int MAX_KEYS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic [SLOT_W-1:0]        key_slot,
  input  logic [TIME_W-1:0]        key_time,
  input  logic signed [VAL_W-1:0]  key_value,
  input  logic [TIME_W-1:0]        query_time,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  target,
  output logic [SEG_W-1:0]         segment
);

  localparam int AW      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int AXW     = (AW > SEG_W) ? AW : SEG_W;
  localparam int KEY_CAP = (MAX_KEYS < 31) ? MAX_KEYS : 31;
  localparam int PW      = VAL_W + 1 + FRAC_BITS;

  // configuration
  logic [SEG_W-1:0] key_count;
  logic             repeat_enable;

  // table
  logic [TIME_W-1:0] time_mem  [MAX_KEYS];
  logic [VAL_W-1:0]  value_mem [MAX_KEYS];
  logic [TIME_W-1:0] rd_time;
  logic [VAL_W-1:0]  rd_value;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              mem_we;

  // sequencer and datapath
  state_t                state;
  logic [SEG_W-1:0]      n_eff;
  logic [SEG_W-1:0]      idx;
  logic [CNT_W-1:0]      cnt;
  logic [TIME_W-1:0]     q;
  logic [TIME_W-1:0]     q_sh;
  logic [TIME_W-1:0]     t_first;
  logic [TIME_W-1:0]     prev_time;
  logic [VAL_W-1:0]      prev_value;
  logic [TIME_W-1:0]     div_d;
  logic [TIME_W-1:0]     rem;
  logic [FRAC_BITS-1:0]  quo;
  logic signed [PW-1:0]  md;
  logic signed [PW-1:0]  acc;

  logic                  in_accept;
  logic                  out_free;
  logic [SEG_W-1:0]      n_cfg;
  logic [TIME_W-1:0]     span;
  logic [TIME_W:0]       rs;
  logic [TIME_W:0]       rs_diff;
  logic                  ge;
  logic [TIME_W-1:0]     rem_next;
  logic [SEG_W-1:0]      idx_inc;
  logic [VAL_W:0]        delta;
  logic signed [VAL_W:0]   prod_shift;
  logic signed [VAL_W+1:0] sum;
  logic signed [VAL_W-1:0] result;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign n_cfg = (key_count > SEG_W'(KEY_CAP)) ? SEG_W'(KEY_CAP) : key_count;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      repeat_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_COUNT: key_count     <= cfg_data[SEG_W-1:0];
        CFG_REPEAT:    repeat_enable <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // table: one write port, one registered read port
  logic [AXW-1:0] slot_ext;
  logic [AXW-1:0] rd_ext;
  logic [SEG_W-1:0] last_idx;

  assign slot_ext = AXW'(key_slot);
  assign wr_addr  = slot_ext[AW-1:0];
  assign mem_we   = in_accept && (action == ACTION_LOAD) &&
                    ({1'b0, key_slot} < SEG_W'(KEY_CAP));
  assign last_idx = n_eff - SEG_W'(1);

  always_comb begin
    case (state)
      S_RD_LAST: rd_ext = AXW'(last_idx);
      S_SRCH_RD: rd_ext = AXW'(idx);
      default:   rd_ext = '0;
    endcase
  end
  assign rd_addr = rd_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[wr_addr]  <= key_time;
      value_mem[wr_addr] <= key_value;
    end
    rd_time  <= time_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

  // shared restoring step: fold remainder and slope quotient
  assign span     = rd_time - t_first;
  assign rs       = {rem, (state == S_FOLD) ? q_sh[TIME_W-1] : 1'b0};
  assign rs_diff  = rs - {1'b0, div_d};
  assign ge       = (rs >= {1'b0, div_d});
  assign rem_next = ge ? rs_diff[TIME_W-1:0] : rs[TIME_W-1:0];
  assign idx_inc  = idx + SEG_W'(1);
  assign delta    = {rd_value[VAL_W-1], rd_value} - {prev_value[VAL_W-1], prev_value};

  // floor(product / 2^FRAC_BITS) is an arithmetic shift
  assign prod_shift = acc[PW-1:FRAC_BITS];
  assign sum        = {prev_value[VAL_W-1], prev_value[VAL_W-1], prev_value} +
                      {prod_shift[VAL_W], prod_shift};
  always_comb begin
    if (sum[VAL_W+1] != sum[VAL_W] || sum[VAL_W] != sum[VAL_W-1]) begin
      result = sum[VAL_W+1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      result = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept && action == ACTION_EVAL && n_cfg != '0) begin
            state <= repeat_enable ? S_RD_FIRST : S_SRCH_RD;
          end
        end
        S_RD_FIRST: state <= S_RD_LAST;
        S_RD_LAST:  state <= S_SPAN;
        S_SPAN: begin
          if (span != '0 && q > span) begin
            state <= S_FOLD;
          end else begin
            state <= S_SRCH_RD;
          end
        end
        S_FOLD: begin
          if (cnt == CNT_W'(TIME_W - 1)) begin
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: state <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (rd_time <= q) begin
            state <= (idx_inc == n_eff) ? S_DONE : S_SRCH_RD;
          end else begin
            state <= (idx == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q     <= query_time;
        n_eff <= n_cfg;
        idx   <= '0;
        acc   <= '0;
      end
      S_RD_LAST: t_first <= rd_time;
      S_SPAN: begin
        div_d <= span;
        rem   <= '0;
        q_sh  <= q;
        cnt   <= '0;
      end
      S_FOLD: begin
        rem  <= rem_next;
        q_sh <= q_sh << 1;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(TIME_W - 1)) begin
          // an exact multiple folds to the span itself
          q <= (rem_next == '0) ? div_d : rem_next;
        end
      end
      S_SRCH_CMP: begin
        if (rd_time <= q) begin
          prev_time  <= rd_time;
          prev_value <= rd_value;
          idx        <= idx_inc;
        end else if (idx == '0) begin
          prev_value <= rd_value;
        end else begin
          div_d <= rd_time - prev_time;
          rem   <= q - prev_time;
          md    <= PW'(signed'(delta));
          cnt   <= '0;
        end
      end
      S_DIV: begin
        rem <= rem_next;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          quo <= (div_d == '0) ? '0 : {quo[FRAC_BITS-2:0], ge};
          cnt <= '0;
        end else begin
          quo <= {quo[FRAC_BITS-2:0], ge};
          cnt <= cnt + CNT_W'(1);
        end
      end
      S_MUL: begin
        if (quo[0]) begin
          acc <= acc + md;
        end
        md  <= md <<< 1;
        quo <= quo >> 1;
        cnt <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      target  <= result;
      segment <= idx;
    end
  end

  `ASSERT_NEXT(a_empty_no_start, in_accept && action == ACTION_EVAL && n_cfg == '0,
    state == S_IDLE, "evaluate on empty table started work")
  `ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state == S_DONE),
    "result appeared outside final step")
  `ASSERT_NOW(a_probe_in_range, state == S_SRCH_CMP, idx < n_eff,
    "table probe beyond key count")
  `ASSERT_NOW(a_segment_bound, out_valid && state == S_IDLE, segment <= n_cfg,
    "segment above key count")

endmodule
